### rtl/mpma_pkg.sv
// ----------------------------------------------------------------------------
// mpma_pkg
// Shared types and constants of the multi-pattern match automaton.
// ----------------------------------------------------------------------------
package mpma_pkg;

  localparam int NODE_CAP  = 4096;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = 12;
  localparam int CNT_W     = 13;
  localparam int SYM_W     = 5;
  localparam int WORD_W    = 10;
  localparam int TROWS     = NODE_CAP * ALPHABET;
  localparam int TADDR_W   = $clog2(TROWS);

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(NODE_CAP);

  localparam logic [2:0] FN_MAP    = 3'd0;
  localparam logic [2:0] FN_CLEAR  = 3'd1;
  localparam logic [2:0] FN_INSERT = 3'd2;
  localparam logic [2:0] FN_FINISH = 3'd3;
  localparam logic [2:0] FN_GO     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BUILT    = 2'd3;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        char_byte;
    logic [SYM_W-1:0]  symbol_index;
    logic              last_of_word;
    logic [WORD_W-1:0] word_number;
    logic [NODE_W-1:0] from_node;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] next_node;
    logic              node_has_word;
    logic [WORD_W-1:0] node_word;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] link;
    logic [NODE_W-1:0] par;
    logic [SYM_W-1:0]  sym;
    logic              mvld;
    logic [WORD_W-1:0] mnum;
  } node_t;

  function automatic logic [TADDR_W-1:0] taddr(input logic [NODE_W-1:0] row,
                                               input logic [SYM_W-1:0] col);
    taddr = TADDR_W'(row) * TADDR_W'(ALPHABET) + TADDR_W'(col);
  endfunction

endpackage

### rtl/mpma_ram.sv
// ----------------------------------------------------------------------------
// mpma_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpma_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/multi_pattern_match_automaton.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_automaton
// Aho-Corasick automaton: byte map, clear, trie insert, breadth-first build, go.
// ----------------------------------------------------------------------------
// Insert zeroes the transition row of a node it creates, entry by entry; clear
//   sweeps the root row; finish answers without a pass when already built, else
//   it walks the trie breadth-first, setting suffix links and filling rows.
// Throughput: one command at a time; busy is high until the done strobe.
// Reset: the root row is swept to zero with busy high, and no done is given.
// The receiver cannot stall; done is high for exactly one cycle per transfer.
module multi_pattern_match_automaton
  import mpma_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_INIT     = 16'h0002,
    S_DEC      = 16'h0004,
    S_GO_T     = 16'h0008,
    S_MARK     = 16'h0010,
    S_INS_T    = 16'h0020,
    S_INS_Z    = 16'h0040,
    S_INS_W    = 16'h0080,
    S_INS_N    = 16'h0100,
    S_BFS_POP  = 16'h0200,
    S_BFS_CUR  = 16'h0400,
    S_BFS_NODE = 16'h0800,
    S_BFS_PL   = 16'h1000,
    S_BFS_SL   = 16'h2000,
    S_BFS_E    = 16'h4000,
    S_BFS_F    = 16'h8000
  } state_t;

  state_t            state, state_next;
  cmd_t              c, c_next;
  logic              quiet, quiet_next;
  logic [SYM_W-1:0]  k, k_next;
  logic [SYM_W-1:0]  sym, sym_next;
  logic [NODE_W-1:0] v, v_next;
  logic [NODE_W-1:0] cursor, cursor_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              built, built_next;
  logic [NODE_W-1:0] cur, cur_next;
  logic [NODE_W-1:0] link, link_next;
  node_t             nd, nd_next;
  logic [CNT_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  tail, tail_next;
  logic              done_next;
  rsp_t              rsp_next;
  logic [255:0]      map_vld;
  logic              map_set;

  logic               t_we;
  logic [TADDR_W-1:0] t_waddr, t_raddr;
  logic [NODE_W-1:0]  t_wdata, t_q;
  logic               n_we;
  logic [NODE_W-1:0]  n_waddr, n_raddr;
  node_t              n_wdata, n_q;
  logic               q_we;
  logic [NODE_W-1:0]  q_waddr, q_wdata, q_q;
  logic               m_we;
  logic [SYM_W-1:0]   m_q;

  mpma_ram #(.DEPTH(TROWS), .WIDTH(NODE_W)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_q)
  );

  mpma_ram #(.DEPTH(NODE_CAP), .WIDTH($bits(node_t))) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_q)
  );

  mpma_ram #(.DEPTH(NODE_CAP), .WIDTH(NODE_W)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head[NODE_W-1:0]), .rdata(q_q)
  );

  mpma_ram #(.DEPTH(256), .WIDTH(SYM_W)) u_map (
    .clk(clk), .we(m_we), .waddr(c.char_byte), .wdata(c.symbol_index),
    .raddr(cmd.char_byte), .rdata(m_q)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    c_next      = c;
    quiet_next  = quiet;
    k_next      = k;
    sym_next    = sym;
    v_next      = v;
    cursor_next = cursor;
    count_next  = count;
    built_next  = built;
    cur_next    = cur;
    link_next   = link;
    nd_next     = nd;
    head_next   = head;
    tail_next   = tail;
    done_next   = 1'b0;
    rsp_next    = rsp;
    map_set     = 1'b0;
    t_we        = 1'b0;
    t_waddr     = '0;
    t_wdata     = '0;
    t_raddr     = '0;
    n_we        = 1'b0;
    n_waddr     = '0;
    n_wdata     = '0;
    n_raddr     = '0;
    q_we        = 1'b0;
    q_waddr     = '0;
    q_wdata     = '0;
    m_we        = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          c_next     = cmd;
          state_next = S_DEC;
        end
      end

      S_INIT: begin
        t_we    = 1'b1;
        t_waddr = taddr('0, k);
        n_we    = (k == '0);
        n_waddr = '0;
        n_wdata = '0;
        k_next  = k + 1'b1;
        if (k == LAST_SYM) begin
          k_next      = '0;
          count_next  = CNT_W'(1);
          cursor_next = '0;
          built_next  = 1'b0;
          state_next  = S_IDLE;
          if (!quiet) begin
            done_next = 1'b1;
            rsp_next  = '0;
          end
          quiet_next = 1'b0;
        end
      end

      S_DEC: begin
        state_next = S_IDLE;
        case (c.func)
          FN_MAP: begin
            done_next = 1'b1;
            rsp_next  = '0;
            if (32'(c.symbol_index) >= ALPHABET) begin
              rsp_next.status = ST_UNMAPPED;
            end else begin
              m_we    = 1'b1;
              map_set = 1'b1;
            end
          end
          FN_CLEAR: begin
            k_next     = '0;
            state_next = S_INIT;
          end
          FN_INSERT: begin
            if (built) begin
              done_next       = 1'b1;
              rsp_next        = '0;
              rsp_next.status = ST_BUILT;
            end else if (!map_vld[c.char_byte]) begin
              done_next       = 1'b1;
              rsp_next        = '0;
              rsp_next.status = ST_UNMAPPED;
            end else begin
              sym_next   = m_q;
              t_raddr    = taddr(cursor, m_q);
              state_next = S_INS_T;
            end
          end
          FN_FINISH: begin
            if (built) begin
              done_next = 1'b1;
              rsp_next  = '0;
            end else begin
              q_we       = 1'b1;
              q_waddr    = '0;
              q_wdata    = '0;
              head_next  = '0;
              tail_next  = CNT_W'(1);
              state_next = S_BFS_POP;
            end
          end
          FN_GO: begin
            if (!map_vld[c.char_byte]) begin
              done_next       = 1'b1;
              rsp_next        = '0;
              rsp_next.status = ST_UNMAPPED;
            end else if ({1'b0, c.from_node} >= count) begin
              v_next     = '0;
              n_raddr    = '0;
              state_next = S_MARK;
            end else begin
              t_raddr    = taddr(c.from_node, m_q);
              state_next = S_GO_T;
            end
          end
          default: begin
            done_next = 1'b1;
            rsp_next  = '0;
          end
        endcase
      end

      S_GO_T: begin
        v_next     = t_q;
        n_raddr    = t_q;
        state_next = S_MARK;
      end

      S_MARK: begin
        done_next              = 1'b1;
        rsp_next.next_node     = v;
        rsp_next.node_has_word = n_q.mvld;
        rsp_next.node_word     = n_q.mvld ? n_q.mnum : '0;
        rsp_next.status        = ST_OK;
        state_next             = S_IDLE;
      end

      S_INS_T: begin
        if (t_q == '0) begin
          if (count >= CNT_MAX) begin
            done_next       = 1'b1;
            rsp_next        = '0;
            rsp_next.status = ST_FULL;
            state_next      = S_IDLE;
          end else begin
            v_next     = count[NODE_W-1:0];
            k_next     = '0;
            state_next = S_INS_Z;
          end
        end else begin
          v_next     = t_q;
          n_raddr    = t_q;
          state_next = S_INS_N;
        end
      end

      S_INS_Z: begin
        t_we    = 1'b1;
        t_waddr = taddr(v, k);
        k_next  = k + 1'b1;
        if (k == LAST_SYM) begin
          k_next     = '0;
          state_next = S_INS_W;
        end
      end

      S_INS_W: begin
        t_we         = 1'b1;
        t_waddr      = taddr(cursor, sym);
        t_wdata      = v;
        n_we         = 1'b1;
        n_waddr      = v;
        n_wdata.link = '0;
        n_wdata.par  = cursor;
        n_wdata.sym  = sym;
        n_wdata.mvld = c.last_of_word;
        n_wdata.mnum = c.last_of_word ? c.word_number : '0;
        count_next   = count + 1'b1;
        cursor_next  = c.last_of_word ? '0 : v;
        done_next              = 1'b1;
        rsp_next.next_node     = v;
        rsp_next.node_has_word = c.last_of_word;
        rsp_next.node_word     = c.last_of_word ? c.word_number : '0;
        rsp_next.status        = ST_OK;
        state_next             = S_IDLE;
      end

      S_INS_N: begin
        done_next          = 1'b1;
        rsp_next.next_node = v;
        rsp_next.status    = ST_OK;
        if (c.last_of_word) begin
          n_we                   = 1'b1;
          n_waddr                = v;
          n_wdata                = n_q;
          n_wdata.mvld           = 1'b1;
          n_wdata.mnum           = c.word_number;
          rsp_next.node_has_word = 1'b1;
          rsp_next.node_word     = c.word_number;
          cursor_next            = '0;
        end else begin
          rsp_next.node_has_word = n_q.mvld;
          rsp_next.node_word     = n_q.mvld ? n_q.mnum : '0;
          cursor_next            = v;
        end
        state_next = S_IDLE;
      end

      S_BFS_POP: begin
        if (head == tail) begin
          built_next = 1'b1;
          done_next  = 1'b1;
          rsp_next   = '0;
          state_next = S_IDLE;
        end else begin
          head_next  = head + 1'b1;
          state_next = S_BFS_CUR;
        end
      end

      S_BFS_CUR: begin
        cur_next   = q_q;
        n_raddr    = q_q;
        state_next = S_BFS_NODE;
      end

      S_BFS_NODE: begin
        nd_next = n_q;
        if (cur != '0 && n_q.par != '0) begin
          n_raddr    = n_q.par;
          state_next = S_BFS_PL;
        end else begin
          link_next  = n_q.link;
          k_next     = '0;
          t_raddr    = taddr(cur, '0);
          state_next = S_BFS_E;
        end
      end

      S_BFS_PL: begin
        t_raddr    = taddr(n_q.link, nd.sym);
        state_next = S_BFS_SL;
      end

      S_BFS_SL: begin
        link_next    = t_q;
        n_we         = 1'b1;
        n_waddr      = cur;
        n_wdata      = nd;
        n_wdata.link = t_q;
        k_next       = '0;
        t_raddr      = taddr(cur, '0);
        state_next   = S_BFS_E;
      end

      S_BFS_E: begin
        if (t_q == '0 && cur != '0) begin
          t_raddr    = taddr(link, k);
          state_next = S_BFS_F;
        end else begin
          if (t_q != '0 && tail < CNT_MAX) begin
            q_we      = 1'b1;
            q_waddr   = tail[NODE_W-1:0];
            q_wdata   = t_q;
            tail_next = tail + 1'b1;
          end
          if (k == LAST_SYM) begin
            state_next = S_BFS_POP;
          end else begin
            k_next  = k + 1'b1;
            t_raddr = taddr(cur, k + 1'b1);
          end
        end
      end

      S_BFS_F: begin
        t_we    = 1'b1;
        t_waddr = taddr(cur, k);
        t_wdata = t_q;
        if (k == LAST_SYM) begin
          state_next = S_BFS_POP;
        end else begin
          k_next     = k + 1'b1;
          t_raddr    = taddr(cur, k + 1'b1);
          state_next = S_BFS_E;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      quiet   <= 1'b1;
      k       <= '0;
      count   <= CNT_W'(1);
      cursor  <= '0;
      built   <= 1'b0;
      head    <= '0;
      tail    <= '0;
      done    <= 1'b0;
      map_vld <= '0;
    end else begin
      state  <= state_next;
      quiet  <= quiet_next;
      k      <= k_next;
      count  <= count_next;
      cursor <= cursor_next;
      built  <= built_next;
      head   <= head_next;
      tail   <= tail_next;
      done   <= done_next;
      if (map_set) begin
        map_vld[c.char_byte] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    c    <= c_next;
    sym  <= sym_next;
    v    <= v_next;
    cur  <= cur_next;
    link <= link_next;
    nd   <= nd_next;
    rsp  <= rsp_next;
  end

endmodule
